// File: rtl/u8sd_pkg.sv
// Package: shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int EVQ_DEPTH           = 2;
  localparam int OUTQ_DEPTH          = 2;
  localparam int CP_W                = 21;
  localparam int LEN_W               = 3;
  localparam int CNT_OUT_W           = 32;

  // Lead byte ranges and second-byte limits for the restricted leads.
  localparam logic [7:0] ASCII_MAX    = 8'h7F;
  localparam logic [7:0] LEAD2_MIN    = 8'hC2;
  localparam logic [7:0] LEAD2_MAX    = 8'hDF;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD3_MAX    = 8'hEF;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD4_MAX    = 8'hF4;
  localparam logic [7:0] LEAD_E0      = 8'hE0;
  localparam logic [7:0] LEAD_ED      = 8'hED;
  localparam logic [7:0] LEAD_F0      = 8'hF0;
  localparam logic [7:0] LEAD_F4      = 8'hF4;
  localparam logic [7:0] E0_SECOND_LO = 8'hA0;
  localparam logic [7:0] ED_SECOND_HI = 8'h9F;
  localparam logic [7:0] F0_SECOND_LO = 8'h90;
  localparam logic [7:0] F4_SECOND_HI = 8'h8F;
  localparam logic [1:0] CONT_TAG     = 2'b10;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             has_code_point;
    logic             is_error;
    logic             end_of_text;
    logic [LEN_W-1:0] len;
  } ev_t;

  typedef struct packed {
    logic [CP_W-1:0]      code_point;
    logic                 has_code_point;
    logic                 is_error;
    logic                 end_of_text;
    logic [CNT_OUT_W-1:0] bytes_consumed;
  } res_t;

endpackage

// File: rtl/u8sd_fifo.sv
// Small register FIFO used for the event queue and the result queue.
module u8sd_fifo import u8sd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/u8sd_front.sv
// Front end: takes text bytes, tracks the open sequence and validates it.
module u8sd_front import u8sd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  input  logic       evq_full,
  output logic       evq_push,
  output ev_t        ev
);

  logic [7:0]      lead_byte, lead_byte_next;
  logic [CP_W-1:0] partial_value, partial_value_next;
  logic [1:0]      bytes_left, bytes_left_next;
  logic [1:0]      seq_position, seq_position_next;
  logic            failed, failed_next;

  logic accept;
  logic emit;
  logic second_ok;
  logic [CP_W-1:0] joined;

  assign accept = push && !evq_full;
  assign joined = {partial_value[CP_W-7:0], text_byte[5:0]};

  always_comb begin
    case (lead_byte)
      LEAD_E0: second_ok = (text_byte >= E0_SECOND_LO);
      LEAD_ED: second_ok = (text_byte <= ED_SECOND_HI);
      LEAD_F0: second_ok = (text_byte >= F0_SECOND_LO);
      LEAD_F4: second_ok = (text_byte <= F4_SECOND_HI);
      default: second_ok = 1'b1;
    endcase
  end

  always_comb begin
    lead_byte_next     = lead_byte;
    partial_value_next = partial_value;
    bytes_left_next    = bytes_left;
    seq_position_next  = seq_position;
    failed_next        = failed;
    emit               = 1'b0;
    ev                 = '0;
    ev.end_of_text     = final_byte;

    if (failed) begin
      if (final_byte) begin
        emit     = 1'b1;
        ev.is_error = 1'b1;
      end
    end else if (bytes_left == 2'd0) begin
      if (text_byte <= ASCII_MAX) begin
        emit              = 1'b1;
        ev.code_point     = CP_W'(text_byte);
        ev.has_code_point = 1'b1;
        ev.len            = LEN_W'(1);
      end else if (text_byte inside {[LEAD2_MIN:LEAD2_MAX]}) begin
        partial_value_next = CP_W'(text_byte[4:0]);
        bytes_left_next    = 2'd1;
        lead_byte_next     = text_byte;
        seq_position_next  = 2'd1;
        emit               = final_byte;
        ev.is_error        = final_byte;
      end else if (text_byte inside {[LEAD3_MIN:LEAD3_MAX]}) begin
        partial_value_next = CP_W'(text_byte[3:0]);
        bytes_left_next    = 2'd2;
        lead_byte_next     = text_byte;
        seq_position_next  = 2'd1;
        emit               = final_byte;
        ev.is_error        = final_byte;
      end else if (text_byte inside {[LEAD4_MIN:LEAD4_MAX]}) begin
        partial_value_next = CP_W'(text_byte[2:0]);
        bytes_left_next    = 2'd3;
        lead_byte_next     = text_byte;
        seq_position_next  = 2'd1;
        emit               = final_byte;
        ev.is_error        = final_byte;
      end else begin
        emit        = 1'b1;
        ev.is_error = 1'b1;
        failed_next = 1'b1;
      end
    end else if ((text_byte[7:6] != CONT_TAG) || (seq_position == 2'd1 && !second_ok)) begin
      emit        = 1'b1;
      ev.is_error = 1'b1;
      failed_next = 1'b1;
    end else begin
      partial_value_next = joined;
      bytes_left_next    = bytes_left - 2'd1;
      seq_position_next  = seq_position + 2'd1;
      if (bytes_left != 2'd1) begin
        emit        = final_byte;
        ev.is_error = final_byte;
      end else begin
        emit              = 1'b1;
        ev.code_point     = joined;
        ev.has_code_point = 1'b1;
        ev.len            = (lead_byte >= LEAD4_MIN) ? LEN_W'(4) :
                            (lead_byte >= LEAD3_MIN) ? LEN_W'(3) : LEN_W'(2);
        lead_byte_next     = '0;
        partial_value_next = '0;
        seq_position_next  = '0;
      end
    end

    // end of text returns the decoder to its reset state
    if (final_byte) begin
      lead_byte_next     = '0;
      partial_value_next = '0;
      bytes_left_next    = '0;
      seq_position_next  = '0;
      failed_next        = 1'b0;
    end
  end

  assign evq_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte     <= '0;
      partial_value <= '0;
      bytes_left    <= '0;
      seq_position  <= '0;
      failed        <= 1'b0;
    end else if (accept) begin
      lead_byte     <= lead_byte_next;
      partial_value <= partial_value_next;
      bytes_left    <= bytes_left_next;
      seq_position  <= seq_position_next;
      failed        <= failed_next;
    end
  end

endmodule

// File: rtl/u8sd_back.sv
// Back end: keeps the saturating byte count and forms result transactions.
module u8sd_back import u8sd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  evq_empty,
  input  ev_t   ev,
  output logic  evq_pop,
  input  logic  outq_full,
  output logic  outq_push,
  output res_t  res
);

  localparam int SW    = COUNT_WIDTH + 1;
  localparam int EXT_W = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

  logic [COUNT_WIDTH-1:0] byte_total, byte_total_next;
  logic [SW-1:0]          sum;
  logic [COUNT_WIDTH-1:0] sat;
  logic [EXT_W-1:0]       sat_ext;

  assign evq_pop   = !evq_empty && !outq_full;
  assign outq_push = evq_pop;

  assign sum     = {1'b0, byte_total} + SW'(ev.len);
  assign sat     = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  assign sat_ext = EXT_W'(sat);

  always_comb begin
    res.code_point     = ev.code_point;
    res.has_code_point = ev.has_code_point;
    res.is_error       = ev.is_error;
    res.end_of_text    = ev.end_of_text;
    res.bytes_consumed = ev.is_error ? '0 : sat_ext[CNT_OUT_W-1:0];

    if (ev.end_of_text) begin
      byte_total_next = '0;
    end else if (ev.is_error) begin
      byte_total_next = byte_total;
    end else begin
      byte_total_next = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
    end else if (evq_pop) begin
      byte_total <= byte_total_next;
    end
  end

endmodule

// File: rtl/utf8_stream_decoder_core.sv
// Top level of the validating UTF-8 stream decoder.
//
//   channel   direction  handshake     fields
//   input     in         push / full   text_byte, final_byte
//   result    out        pop / empty   code_point, has_code_point, is_error,
//                                      end_of_text, bytes_consumed
//
// One byte per cycle is taken while full is low; the front end writes the
// event queue at the edge that accepts the byte, and the count stage moves the
// event to the result queue whenever that queue is not full; there it is on
// the result ports until it is popped.
// Each side stalls on its own through the two-entry queues.
// Synchronous reset clears the decode state, the byte count and both queues.
module utf8_stream_decoder_core import u8sd_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           text_byte,
  input  logic                 final_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [CP_W-1:0]      code_point,
  output logic                 has_code_point,
  output logic                 is_error,
  output logic                 end_of_text,
  output logic [CNT_OUT_W-1:0] bytes_consumed
);

  localparam int EV_W  = $bits(ev_t);
  localparam int RES_W = $bits(res_t);

  logic  evq_push;
  logic  outq_push;
  ev_t   ev_in;
  ev_t   ev_out;
  res_t  res_in;
  res_t  res_out;
  logic  evq_full;
  logic  evq_empty;
  logic  evq_pop;
  logic  outq_full;

  assign full = evq_full;

  u8sd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .evq_full   (evq_full),
    .evq_push   (evq_push),
    .ev         (ev_in)
  );

  u8sd_fifo #(
    .WIDTH (EV_W),
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst   (rst),
    .push  (evq_push),
    .din   (ev_in),
    .full  (evq_full),
    .pop   (evq_pop),
    .dout  (ev_out),
    .empty (evq_empty)
  );

  u8sd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .evq_empty (evq_empty),
    .ev        (ev_out),
    .evq_pop   (evq_pop),
    .outq_full (outq_full),
    .outq_push (outq_push),
    .res       (res_in)
  );

  u8sd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (outq_push),
    .din   (res_in),
    .full  (outq_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign code_point     = res_out.code_point;
  assign has_code_point = res_out.has_code_point;
  assign is_error       = res_out.is_error;
  assign end_of_text    = res_out.end_of_text;
  assign bytes_consumed = res_out.bytes_consumed;

endmodule

// File: tb/tb_utf8_stream_decoder_core.sv
// Self-checking testbench for the UTF-8 stream decoder: directed rows, then random text.
module tb_utf8_stream_decoder_core;
  import u8sd_pkg::*;

  localparam int CW          = COUNT_WIDTH_DEFAULT;
  localparam int DIR_ROWS    = 25;
  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [7:0]           text_byte;
  logic                 final_byte;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [CP_W-1:0]      code_point;
  logic                 has_code_point;
  logic                 is_error;
  logic                 end_of_text;
  logic [CNT_OUT_W-1:0] bytes_consumed;

  utf8_stream_decoder_core dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .text_byte      (text_byte),
    .final_byte     (final_byte),
    .empty          (empty),
    .pop            (pop),
    .code_point     (code_point),
    .has_code_point (has_code_point),
    .is_error       (is_error),
    .end_of_text    (end_of_text),
    .bytes_consumed (bytes_consumed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state mirror
  logic [7:0]      dec_lead;
  logic [CP_W-1:0] dec_partial;
  logic [1:0]      dec_left;
  logic [1:0]      dec_pos;
  logic [CW-1:0]   dec_total;
  logic            dec_failed;

  res_t       decoded_q [$];
  text_item_t text_q [$];
  int         mismatches    = 0;
  int         useful_items  = 0;
  int         quiet_cycles  = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_req      = 1'b0;
  logic       row_typed     = 1'b0;
  res_t       row_want      = '0;

  function automatic res_t mk_result(input logic [CP_W-1:0] cp, input logic has,
                                     input logic err, input logic eot,
                                     input logic [CNT_OUT_W-1:0] cnt);
    res_t r;
    r.code_point     = cp;
    r.has_code_point = has;
    r.is_error       = err;
    r.end_of_text    = eot;
    r.bytes_consumed = cnt;
    return r;
  endfunction

  function automatic void clear_decoder();
    dec_lead    = '0;
    dec_partial = '0;
    dec_left    = '0;
    dec_pos     = '0;
    dec_total   = '0;
    dec_failed  = 1'b0;
  endfunction

  function automatic void add_bytes(input int n);
    logic [CW:0] sum;
    sum = {1'b0, dec_total} + (CW+1)'(n);
    if (sum[CW]) begin
      dec_total = '1;
    end else begin
      dec_total = sum[CW-1:0];
    end
  endfunction

  function automatic logic flag_malformed(input logic fin, output res_t r);
    r = mk_result('0, 1'b0, 1'b1, fin, '0);
    if (fin) begin
      clear_decoder();
    end else begin
      dec_failed = 1'b1;
    end
    return 1'b1;
  endfunction

  // returns 1 when the byte yields a result
  function automatic logic decode_byte(input logic [7:0] b, input logic fin, output res_t r);
    logic second_ok;
    int   len;
    r = '0;
    if (dec_failed) begin
      if (!fin) return 1'b0;
      r = mk_result('0, 1'b0, 1'b1, 1'b1, '0);
      clear_decoder();
      return 1'b1;
    end
    if (dec_left == 0) begin
      if (b <= ASCII_MAX) begin
        add_bytes(1);
        r = mk_result(CP_W'(b), 1'b1, 1'b0, fin, dec_total);
        if (fin) clear_decoder();
        return 1'b1;
      end
      if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        dec_partial = CP_W'(b[4:0]);
        dec_left    = 2'd1;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        dec_partial = CP_W'(b[3:0]);
        dec_left    = 2'd2;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        dec_partial = CP_W'(b[2:0]);
        dec_left    = 2'd3;
      end else begin
        return flag_malformed(fin, r);
      end
      dec_lead = b;
      dec_pos  = 2'd1;
      if (fin) return flag_malformed(fin, r);
      return 1'b0;
    end
    if (b[7:6] != CONT_TAG) return flag_malformed(fin, r);
    case (dec_lead)
      LEAD_E0: second_ok = (b >= E0_SECOND_LO);
      LEAD_ED: second_ok = (b <= ED_SECOND_HI);
      LEAD_F0: second_ok = (b >= F0_SECOND_LO);
      LEAD_F4: second_ok = (b <= F4_SECOND_HI);
      default: second_ok = 1'b1;
    endcase
    if (dec_pos == 2'd1 && !second_ok) return flag_malformed(fin, r);
    dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
    dec_left    = dec_left - 2'd1;
    dec_pos     = dec_pos + 2'd1;
    if (dec_left != 0) begin
      if (fin) return flag_malformed(fin, r);
      return 1'b0;
    end
    len = (dec_lead >= LEAD4_MIN) ? 4 : (dec_lead >= LEAD3_MIN) ? 3 : 2;
    add_bytes(len);
    r = mk_result(dec_partial, 1'b1, 1'b0, fin, dec_total);
    dec_lead    = '0;
    dec_partial = '0;
    dec_pos     = '0;
    if (fin) clear_decoder();
    return 1'b1;
  endfunction

  function automatic dir_row_t dir_item(input logic [7:0] value, input logic last,
                                        input logic typed, input res_t want);
    dir_row_t r;
    r.value = value;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // directed rows: typed expectations only where obvious, the rest go to the predictor
  function automatic dir_row_t dir_row(input int i);
    res_t err_mid;
    res_t err_end;
    err_mid = mk_result('0, 1'b0, 1'b1, 1'b0, '0);
    err_end = mk_result('0, 1'b0, 1'b1, 1'b1, '0);
    case (i)
      0:  return dir_item(8'h00, 1'b0, 1'b1, mk_result('0, 1'b1, 1'b0, 1'b0, 1));
      1:  return dir_item(8'h7F, 1'b0, 1'b1, mk_result(21'h7F, 1'b1, 1'b0, 1'b0, 2));
      2:  return dir_item(8'hE0, 1'b0, 1'b0, '0);
      3:  return dir_item(8'hA0, 1'b0, 1'b0, '0);
      4:  return dir_item(8'h80, 1'b0, 1'b0, '0);
      5:  return dir_item(8'hF4, 1'b0, 1'b0, '0);
      6:  return dir_item(8'h8F, 1'b0, 1'b0, '0);
      7:  return dir_item(8'hBF, 1'b0, 1'b0, '0);
      8:  return dir_item(8'hBF, 1'b1, 1'b0, '0);
      9:  return dir_item(8'h80, 1'b0, 1'b1, err_mid);   // stray continuation
      10: return dir_item(8'h41, 1'b1, 1'b1, err_end);   // end after error
      11: return dir_item(8'hC0, 1'b1, 1'b1, err_end);   // overlong lead
      12: return dir_item(8'hF5, 1'b1, 1'b1, err_end);   // lead above range
      13: return dir_item(8'hE0, 1'b0, 1'b0, '0);
      14: return dir_item(8'h9F, 1'b1, 1'b1, err_end);   // overlong 3-byte
      15: return dir_item(8'hED, 1'b0, 1'b0, '0);
      16: return dir_item(8'hA0, 1'b1, 1'b1, err_end);   // surrogate
      17: return dir_item(8'hF0, 1'b0, 1'b0, '0);
      18: return dir_item(8'h8F, 1'b1, 1'b1, err_end);   // overlong 4-byte
      19: return dir_item(8'hF4, 1'b0, 1'b0, '0);
      20: return dir_item(8'h90, 1'b1, 1'b1, err_end);   // above 10FFFF
      21: return dir_item(8'hC2, 1'b0, 1'b0, '0);
      22: return dir_item(8'h41, 1'b1, 1'b1, err_end);   // bad continuation
      23: return dir_item(8'hE1, 1'b0, 1'b0, '0);
      default: return dir_item(8'h80, 1'b1, 1'b1, err_end);  // truncated by end
    endcase
  endfunction

  function automatic logic [CP_W-1:0] pick_code_point();
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    logic [CP_W-1:0] cp;
    int              len;
    int              r;
    len = $urandom_range(3);
    case (len)
      0:       begin lo = 21'h0;     hi = 21'h7F;     end
      1:       begin lo = 21'h80;    hi = 21'h7FF;    end
      2:       begin lo = 21'h800;   hi = 21'hFFFF;   end
      default: begin lo = 21'h10000; hi = 21'h10FFFF; end
    endcase
    r = $urandom_range(7);
    if (r == 0) begin
      cp = lo;
    end else if (r == 1) begin
      cp = hi;
    end else if (r == 2 && len == 2) begin
      cp = $urandom_range(1) ? 21'hD7FF : 21'hE000;
    end else begin
      cp = CP_W'($urandom_range(hi, lo));
    end
    if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
    return cp;
  endfunction

  // byte i of the sequence sits at seq[8*i +: 8]
  function automatic int utf8_encode(input logic [CP_W-1:0] cp, output logic [31:0] seq);
    seq = '0;
    if (cp <= 21'h7F) begin
      seq[7:0] = cp[7:0];
      return 1;
    end
    if (cp <= 21'h7FF) begin
      seq[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
      return 2;
    end
    if (cp <= 21'hFFFF) begin
      seq[23:0] = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      return 3;
    end
    seq = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    return 4;
  endfunction

  task automatic queue_text();
    int         nchars;
    int         n;
    int         kind;
    logic [31:0] seq;
    logic [7:0] lead;
    text_item_t it;
    nchars = $urandom_range(16, 1);
    for (int c = 0; c < nchars; c++) begin
      kind = $urandom_range(99);
      n = utf8_encode(pick_code_point(), seq);
      if (kind >= 75 && kind < 82 && n > 1) begin
        n = $urandom_range(n - 1, 1);
      end else if (kind >= 82 && kind < 89 && n > 1) begin
        seq[8*$urandom_range(n - 1, 1) +: 8] = 8'($urandom_range(255));
      end else if (kind >= 89 && kind < 95) begin
        case ($urandom_range(3))
          0:       lead = LEAD_E0;
          1:       lead = LEAD_ED;
          2:       lead = LEAD_F0;
          default: lead = LEAD_F4;
        endcase
        seq = {2'b10, 6'($urandom), 2'b10, 6'($urandom), 2'b10, 6'($urandom), lead};
        n = (lead >= LEAD4_MIN) ? 4 : 3;
      end else if (kind >= 95) begin
        seq[7:0] = 8'($urandom_range(255));
        n = 1;
      end
      for (int i = 0; i < n; i++) begin
        it.value = seq[8*i +: 8];
        it.last  = 1'b0;
        text_q.push_back(it);
      end
    end
    it = text_q.pop_back();
    it.last = 1'b1;
    text_q.push_back(it);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last, input logic typed,
                           input res_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    row_typed = typed;
    row_want  = want;
    push       <= 1'b1;
    text_byte  <= value;
    final_byte <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_text_items(input int n);
    int         stop_at;
    text_item_t it;
    stop_at = useful_items + n;
    while (useful_items < stop_at) begin
      queue_text();
      while (text_q.size() != 0) begin
        it = text_q.pop_front();
        send_byte(it.value, it.last, 1'b0, '0);
      end
    end
  endtask

  task automatic wait_all_decoded();
    @(negedge clk);
    push <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always begin
    @(negedge clk);
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_req) begin
      pop <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    res_t got;
    if (!rst) begin
      quiet_cycles++;
      if (push && !full) begin
        quiet_cycles = 0;
        useful_items++;
        if (row_typed) begin
          void'(decode_byte(text_byte, final_byte, want));
          decoded_q.push_back(row_want);
        end else if (decode_byte(text_byte, final_byte, want)) begin
          decoded_q.push_back(want);
        end
      end
      if (pop && !empty) begin
        quiet_cycles = 0;
        got = mk_result(code_point, has_code_point, is_error, end_of_text, bytes_consumed);
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: cp %0h has %b err %b end %b count %0d",
                     got.code_point, got.has_code_point, got.is_error, got.end_of_text,
                     got.bytes_consumed);
        end else begin
          want = decoded_q.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(got.code_point));
          check_field("has_code_point", 32'(want.has_code_point), 32'(got.has_code_point));
          check_field("is_error", 32'(want.is_error), 32'(got.is_error));
          check_field("end_of_text", 32'(want.end_of_text), 32'(got.end_of_text));
          check_field("bytes_consumed", want.bytes_consumed, got.bytes_consumed);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    rst        = 1'b1;
    push       = 1'b0;
    text_byte  = '0;
    final_byte = 1'b0;
    clear_decoder();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 61;
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      send_byte(row.value, row.last, row.typed, row.want);
    end

    // receiver holds off while the sender keeps offering bytes
    hold_req = 1'b1;
    send_text_items(PHASE_ITEMS);
    wait_all_decoded();

    send_idle_pct = 61;
    recv_idle_pct = 34;
    send_text_items(PHASE_ITEMS);
    wait_all_decoded();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_text_items(PHASE_ITEMS);
    wait_all_decoded();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
